>>> rtl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared types and constants for the vertex transform / perspective divide unit.
// ----------------------------------------------------------------------------
package vtpd_pkg;

  // fixed-point format of all coordinates and coefficients
  localparam int FRAC_BITS = 16;

  // signed width of a transformed coordinate (three floored products plus bias)
  localparam int SUM_W = 66 - FRAC_BITS;

  // width of the scaled dividend |N| << FRAC_BITS and of its part above bit 31
  localparam int DIV_W = SUM_W + FRAC_BITS;
  localparam int HI_W = DIV_W - 32;

  // one restoring step per quotient bit
  localparam int DIV_STAGES = 32;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  // input beat
  typedef struct packed {
    logic               command;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } item_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               range_fault;
  } result_t;

  // transformed homogeneous point
  typedef struct packed {
    logic signed [SUM_W-1:0] tx;
    logic signed [SUM_W-1:0] ty;
    logic signed [SUM_W-1:0] tz;
    logic signed [SUM_W-1:0] tw;
  } hvec_t;

  // point with its valid flag, between front and back
  typedef struct packed {
    logic  valid;
    hvec_t data;
  } hbeat_t;

endpackage

>>> rtl/vtpd_front.sv
// ----------------------------------------------------------------------------
// vtpd_front
// Takes input beats, applies coefficient loads to the matrix and forms the
// homogeneous product (X, Y, Z, W) of each transform in two stages.
// ----------------------------------------------------------------------------
module vtpd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vtpd_pkg::item_t item,
  output logic            full,
  input  logic            q_full,
  output vtpd_pkg::hbeat_t hv
);
  import vtpd_pkg::*;

  logic               en;
  logic               accept;
  logic signed [31:0] coeffs [16];

  logic               s1_valid;
  logic signed [63:0] prod [12];
  logic signed [31:0] bias [4];

  logic               s2_valid;
  hvec_t              s2_data;
  logic signed [SUM_W-1:0] rows [4];

  assign en     = !q_full;
  assign full   = q_full;
  assign accept = push && en;

  // coefficient storage, written by load beats
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) coeffs[i] <= '0;
    end else if (accept && item.command == CMD_LOAD) begin
      coeffs[item.coeff_index] <= item.coeff_value;
    end
  end

  // stage 1: the twelve products, taken with the matrix as of acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept && item.command == CMD_XFORM;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod[r]     <= coeffs[r] * item.vertex_x;
        prod[4 + r] <= coeffs[4 + r] * item.vertex_y;
        prod[8 + r] <= coeffs[8 + r] * item.vertex_z;
        bias[r]     <= coeffs[12 + r];
      end
    end
  end

  // stage 2: floor each product to the fixed-point scale and sum per row
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rows[r] = SUM_W'(bias[r])
              + SUM_W'(prod[r] >>> FRAC_BITS)
              + SUM_W'(prod[4 + r] >>> FRAC_BITS)
              + SUM_W'(prod[8 + r] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_data.tx <= rows[0];
      s2_data.ty <= rows[1];
      s2_data.tz <= rows[2];
      s2_data.tw <= rows[3];
    end
  end

  // hand off to the queue
  assign hv.valid = s2_valid && en;
  assign hv.data  = s2_data;

endmodule

>>> rtl/vtpd_queue.sv
// ----------------------------------------------------------------------------
// vtpd_queue
// Two-entry queue of transformed points between the front and the back.
// ----------------------------------------------------------------------------
module vtpd_queue (
  input  logic             clk,
  input  logic             rst,
  input  vtpd_pkg::hbeat_t wr,
  output logic             full,
  output vtpd_pkg::hbeat_t head,
  input  logic             take
);
  import vtpd_pkg::*;

  hvec_t      mem [2];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (wr.valid) wp <= !wp;
      if (take) rp <= !rp;
      cnt <= cnt + 2'(wr.valid) - 2'(take);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr.valid) mem[wp] <= wr.data;
  end

  assign full       = (cnt == 2'd2);
  assign head.valid = (cnt != 2'd0);
  assign head.data  = mem[rp];

endmodule

>>> rtl/vtpd_back.sv
// ----------------------------------------------------------------------------
// vtpd_back
// Divides X, Y and Z by W: magnitudes, a 32-step restoring divider pipeline
// for the three lanes, saturation and sign, and a two-entry result queue.
// ----------------------------------------------------------------------------
module vtpd_back (
  input  logic              clk,
  input  logic              rst,
  input  vtpd_pkg::hbeat_t  head,
  output logic              take,
  output vtpd_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import vtpd_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [31:0]      dlo;
    logic [31:0]      quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic [SUM_W-1:0] den;
    logic             wz;
    lane_t [2:0]      ln;
  } dstage_t;

  function automatic logic [SUM_W-1:0] magnitude(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic             en;
  logic             a_vld;
  logic [SUM_W-1:0] a_mag [3];
  logic             a_neg [3];
  logic [SUM_W-1:0] a_den;
  logic             a_wz;

  logic [DIV_W-1:0] dd [3];
  logic [HI_W-1:0]  hi [3];
  dstage_t          init;

  dstage_t             st [DIV_STAGES+1];
  logic [DIV_STAGES:0] sv;

  dstage_t     last;
  logic [31:0] limit [3];
  logic [31:0] mag [3];
  logic        sat [3];
  logic [31:0] val [3];
  result_t     fin;
  logic        opush;
  logic        opop;

  result_t    ob [2];
  logic [1:0] ocnt;
  logic       owp;
  logic       orp;

  assign en   = (ocnt != 2'd2);
  assign take = en && head.valid;

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag[0] <= magnitude(head.data.tx);
      a_mag[1] <= magnitude(head.data.ty);
      a_mag[2] <= magnitude(head.data.tz);
      a_neg[0] <= head.data.tx[SUM_W-1] ^ head.data.tw[SUM_W-1];
      a_neg[1] <= head.data.ty[SUM_W-1] ^ head.data.tw[SUM_W-1];
      a_neg[2] <= head.data.tz[SUM_W-1] ^ head.data.tw[SUM_W-1];
      a_den    <= magnitude(head.data.tw);
      a_wz     <= (head.data.tw == '0);
    end
  end

  // divider setup: a quotient of 2^32 or more shows in the top dividend bits
  always_comb begin
    init.den = a_den;
    init.wz  = a_wz;
    for (int i = 0; i < 3; i++) begin
      dd[i]          = {a_mag[i], {FRAC_BITS{1'b0}}};
      hi[i]          = dd[i][DIV_W-1:32];
      init.ln[i].rem = SUM_W'(hi[i]);
      init.ln[i].dlo = dd[i][31:0];
      init.ln[i].quo = '0;
      init.ln[i].neg = a_neg[i];
      init.ln[i].ovf = (SUM_W'(hi[i]) >= a_den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st[0] <= init;
  end

  // one quotient bit per stage, three lanes side by side
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    dstage_t        nx;
    logic [SUM_W:0] t [3];

    always_comb begin
      nx = st[k-1];
      for (int i = 0; i < 3; i++) begin
        t[i] = {st[k-1].ln[i].rem, st[k-1].ln[i].dlo[31]};
        if (t[i] >= {1'b0, st[k-1].den}) begin
          nx.ln[i].rem = SUM_W'(t[i] - {1'b0, st[k-1].den});
          nx.ln[i].quo = {st[k-1].ln[i].quo[30:0], 1'b1};
        end else begin
          nx.ln[i].rem = t[i][SUM_W-1:0];
          nx.ln[i].quo = {st[k-1].ln[i].quo[30:0], 1'b0};
        end
        nx.ln[i].dlo = {st[k-1].ln[i].dlo[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= sv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) st[k] <= nx;
    end
  end

  // saturation, sign and the zero-w case
  assign last = st[DIV_STAGES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      limit[i] = last.ln[i].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat[i]   = last.ln[i].ovf || (last.ln[i].quo > limit[i]);
      mag[i]   = sat[i] ? limit[i] : last.ln[i].quo;
      val[i]   = last.ln[i].neg ? (~mag[i] + 1'b1) : mag[i];
    end
    if (last.wz) begin
      fin.out_x       = '0;
      fin.out_y       = '0;
      fin.out_z       = '0;
      fin.range_fault = 1'b1;
    end else begin
      fin.out_x       = val[0];
      fin.out_y       = val[1];
      fin.out_z       = val[2];
      fin.range_fault = sat[0] || sat[1] || sat[2];
    end
  end

  // result queue
  assign opush = en && sv[DIV_STAGES];
  assign opop  = pop && (ocnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
      owp  <= 1'b0;
      orp  <= 1'b0;
    end else begin
      if (opush) owp <= !owp;
      if (opop) orp <= !orp;
      ocnt <= ocnt + 2'(opush) - 2'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) ob[owp] <= fin;
  end

  assign result = ob[orp];
  assign empty  = (ocnt == 2'd0);

endmodule

>>> rtl/vertex_transform_perspective_divide_unit.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_unit
// 4x4 homogeneous vertex transform with perspective divide, signed fixed point.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while full is low. A load beat writes one
// column-major coefficient and gives no result; a transform beat sees every
// load accepted before it and gives one result of X/W, Y/W, Z/W with
// range_fault set when W is zero (outputs zero) or a quotient saturates. A
// beat passes 38 register stages, the first loaded at the edge that accepts
// it: two for the multiply and row sums, one in the mid queue, one for
// magnitudes, one for divider setup, 32 for the restoring divider pipeline
// (one quotient bit per stage) and one in the result queue. Both sides stall
// independently: a full result queue holds the back and a full mid queue
// holds the front and raises full.
module vertex_transform_perspective_divide_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vtpd_pkg::item_t   item,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output vtpd_pkg::result_t result
);
  import vtpd_pkg::*;

  hbeat_t hv;
  hbeat_t head;
  logic   q_full;
  logic   take;

  // front: loads, products, row sums
  vtpd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .hv     (hv)
  );

  // queue between front and back
  vtpd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (hv),
    .full (q_full),
    .head (head),
    .take (take)
  );

  // back: divide, saturate, result queue
  vtpd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .take   (take),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

endmodule
